// File: rtl/vsc_pkg.sv
package vsc_pkg;

   localparam int unsigned MAX_DIM_X_DEFAULT = 256;
   localparam int unsigned MAX_DIM_Y_DEFAULT = 256;
   localparam int unsigned MAX_DIM_Z_DEFAULT = 256;

   localparam int unsigned SIZE_W    = 9;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned POS_W     = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_X_RESET = 9'd200;
   localparam logic [SIZE_W-1:0] SIZE_Y_RESET = 9'd200;
   localparam logic [SIZE_W-1:0] SIZE_Z_RESET = 9'd100;

   typedef enum logic [1:0] {
      CLASS_EMPTY    = 2'd0,
      CLASS_INTERIOR = 2'd1,
      CLASS_SURFACE  = 2'd2
   } voxel_class_type;

   typedef struct packed {
      logic has_prev;
      logic last_plane;
      logic last_voxel;
      logic border;
   } item_flags_type;

   function automatic int unsigned last_index(logic [SIZE_W-1:0] size, int unsigned max_dim);
      int unsigned s;
      s = int'(size);
      if (s == 0) begin
         return 0;
      end
      if (s > max_dim) begin
         return max_dim - 1;
      end
      return s - 1;
   endfunction

endpackage

// File: rtl/voxel_surface_classifier_core.sv
// Order: a voxel's class word passes from the classify stage into the output register
// once the word one plane above it is accepted; a last-plane voxel's own word follows it.
// Throughput: one word per cycle while the output register is free; a word in the last plane
// with a plane below gives two results and holds the input side until the second is sent.
// Reset: sizes return to 200 x 200 x 100 and the position to 0,0,0; the plane
// store keeps its contents, and stale entries may be read but never decide a class.
module voxel_surface_classifier_core #(
   parameter int unsigned MAX_DIM_X = vsc_pkg::MAX_DIM_X_DEFAULT,
   parameter int unsigned MAX_DIM_Y = vsc_pkg::MAX_DIM_Y_DEFAULT,
   parameter int unsigned MAX_DIM_Z = vsc_pkg::MAX_DIM_Z_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [vsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vsc_pkg::SIZE_W-1:0]      csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_occupied,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [vsc_pkg::POS_W-1:0]       rsp_pos_x,
   output logic [vsc_pkg::POS_W-1:0]       rsp_pos_y,
   output logic [vsc_pkg::POS_W-1:0]       rsp_pos_z,
   output logic [1:0]                      rsp_voxel_class,
   output logic                            rsp_last_of_volume
);

   localparam int unsigned XW    = $clog2(MAX_DIM_X);
   localparam int unsigned YW    = $clog2(MAX_DIM_Y);
   localparam int unsigned ZW    = $clog2(MAX_DIM_Z);
   localparam int unsigned AW    = XW + YW - 1;
   localparam int unsigned DEPTH = 2 ** AW;

   // configuration
   logic [vsc_pkg::SIZE_W-1:0] size_x_ff, size_x_in;
   logic [vsc_pkg::SIZE_W-1:0] size_y_ff, size_y_in;
   logic [vsc_pkg::SIZE_W-1:0] size_z_ff, size_z_in;
   logic                       restart;
   logic [XW-1:0]              last_x;
   logic [YW-1:0]              last_y;
   logic [ZW-1:0]              last_z;

   // input position
   logic [XW-1:0] in_x_ff, in_x_in;
   logic [YW-1:0] in_y_ff, in_y_in;
   logic [ZW-1:0] in_z_ff, in_z_in;
   logic [YW-1:0] y_up;
   logic [YW-1:0] y_down;
   logic [AW-1:0] addr_c;
   logic [AW-1:0] addr_r;
   logic [AW-1:0] addr_u;
   logic [AW-1:0] addr_d;
   vsc_pkg::item_flags_type flags_c;
   logic          accept;

   // plane store banks, indexed by {z parity, y parity}
   wire [3:0] bank_rd0;
   wire [3:0] bank_rd1;

   // classify stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_a_done_ff, s1_a_done_in;
   logic [XW-1:0]           s1_x_ff;
   logic [YW-1:0]           s1_y_ff;
   logic [ZW-1:0]           s1_z_ff;
   logic                    s1_cur_ff;
   logic                    s1_left_ff;
   vsc_pkg::item_flags_type s1_flags_ff;
   logic [1:0]              sel_c;
   logic [1:0]              sel_u;
   logic [1:0]              sel_b;
   logic                    nb_center;
   logic                    nb_right;
   logic                    nb_up;
   logic                    nb_down;
   logic                    nb_below;
   logic [ZW-1:0]           zc;
   vsc_pkg::voxel_class_type class_a;
   vsc_pkg::voxel_class_type class_b;
   logic                    out_free;
   logic                    need_a;
   logic                    need_b;
   logic                    emit_a;
   logic                    emit_b;
   logic                    s1_done;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [vsc_pkg::POS_W-1:0]  rsp_pos_x_ff, rsp_pos_x_in;
   logic [vsc_pkg::POS_W-1:0]  rsp_pos_y_ff, rsp_pos_y_in;
   logic [vsc_pkg::POS_W-1:0]  rsp_pos_z_ff, rsp_pos_z_in;
   vsc_pkg::voxel_class_type   rsp_class_ff, rsp_class_in;
   logic                       rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- config
   assign last_x = XW'(vsc_pkg::last_index(size_x_ff, MAX_DIM_X));
   assign last_y = YW'(vsc_pkg::last_index(size_y_ff, MAX_DIM_Y));
   assign last_z = ZW'(vsc_pkg::last_index(size_z_ff, MAX_DIM_Z));

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      restart   = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            vsc_pkg::CSR_SIZE_X: begin
               size_x_in = csr_write_data;
               restart   = 1'b1;
            end
            vsc_pkg::CSR_SIZE_Y: begin
               size_y_in = csr_write_data;
               restart   = 1'b1;
            end
            vsc_pkg::CSR_SIZE_Z: begin
               size_z_in = csr_write_data;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- position
   assign accept = req_valid && !req_stall;

   always_comb begin
      in_x_in = in_x_ff;
      in_y_in = in_y_ff;
      in_z_in = in_z_ff;
      if (restart) begin
         in_x_in = '0;
         in_y_in = '0;
         in_z_in = '0;
      end else if (accept) begin
         if (in_x_ff != last_x) begin
            in_x_in = XW'(in_x_ff + 1'b1);
         end else begin
            in_x_in = '0;
            if (in_y_ff != last_y) begin
               in_y_in = YW'(in_y_ff + 1'b1);
            end else begin
               in_y_in = '0;
               if (in_z_ff != last_z) begin
                  in_z_in = ZW'(in_z_ff + 1'b1);
               end else begin
                  in_z_in = '0;
               end
            end
         end
      end
   end

   assign y_up   = YW'(in_y_ff - 1'b1);
   assign y_down = YW'(in_y_ff + 1'b1);
   assign addr_c = {in_y_ff[YW-1:1], in_x_ff};
   assign addr_r = {in_y_ff[YW-1:1], XW'(in_x_ff + 1'b1)};
   assign addr_u = {y_up[YW-1:1], in_x_ff};
   assign addr_d = {y_down[YW-1:1], in_x_ff};

   always_comb begin
      flags_c.has_prev   = in_z_ff != '0;
      flags_c.last_plane = in_z_ff == last_z;
      flags_c.last_voxel = (in_x_ff == last_x) && (in_y_ff == last_y);
      flags_c.border     = (in_x_ff == '0) || (in_y_ff == '0) || (in_x_ff == last_x) ||
                           (in_y_ff == last_y) || (in_z_ff == ZW'(1));
   end

   // ---------------------------------------------------------------- plane store
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic BANK_Z = (b >= 2);
      localparam logic BANK_Y = ((b % 2) == 1);

      logic          mem [DEPTH];
      logic          rd0_ff;
      logic          rd1_ff;
      logic [AW-1:0] ra0;
      logic [AW-1:0] ra1;
      logic          we;

      always_comb begin
         we  = 1'b0;
         ra0 = addr_c;
         ra1 = addr_c;
         if (BANK_Z == in_z_ff[0]) begin
            we = accept && (BANK_Y == in_y_ff[0]);
         end else if (BANK_Y == in_y_ff[0]) begin
            ra1 = addr_r;
         end else begin
            ra0 = addr_u;
            ra1 = addr_d;
         end
      end

      always_ff @(posedge clock) begin
         if (accept) begin
            rd0_ff <= mem[ra0];
            rd1_ff <= mem[ra1];
         end
         if (we) begin
            mem[addr_c] <= req_occupied;
         end
      end

      assign bank_rd0[b] = rd0_ff;
      assign bank_rd1[b] = rd1_ff;
   end

   // ---------------------------------------------------------------- classify
   assign sel_c = {~s1_z_ff[0], s1_y_ff[0]};
   assign sel_u = {~s1_z_ff[0], ~s1_y_ff[0]};
   assign sel_b = {s1_z_ff[0], s1_y_ff[0]};

   assign nb_center = bank_rd0[sel_c];
   assign nb_right  = bank_rd1[sel_c];
   assign nb_up     = bank_rd0[sel_u];
   assign nb_down   = bank_rd1[sel_u];
   assign nb_below  = bank_rd0[sel_b];
   assign zc        = ZW'(s1_z_ff - 1'b1);

   always_comb begin
      if (!nb_center) begin
         class_a = vsc_pkg::CLASS_EMPTY;
      end else if (s1_flags_ff.border) begin
         class_a = vsc_pkg::CLASS_SURFACE;
      end else if (s1_left_ff && nb_right && nb_up && nb_down && nb_below && s1_cur_ff) begin
         class_a = vsc_pkg::CLASS_INTERIOR;
      end else begin
         class_a = vsc_pkg::CLASS_SURFACE;
      end
      class_b = s1_cur_ff ? vsc_pkg::CLASS_SURFACE : vsc_pkg::CLASS_EMPTY;
   end

   // ---------------------------------------------------------------- flow control
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign need_a   = s1_valid_ff && s1_flags_ff.has_prev && !s1_a_done_ff;
   assign need_b   = s1_valid_ff && s1_flags_ff.last_plane;
   assign emit_a   = need_a && out_free;
   assign emit_b   = !need_a && need_b && out_free;

   always_comb begin
      if (!s1_valid_ff) begin
         s1_done = 1'b0;
      end else if (need_a) begin
         s1_done = out_free && !s1_flags_ff.last_plane;
      end else if (need_b) begin
         s1_done = out_free;
      end else begin
         s1_done = 1'b1;
      end
   end

   assign req_stall = s1_valid_ff && !s1_done;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_a_done_in = s1_a_done_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_a_done_in = 1'b0;
      end else if (s1_done) begin
         s1_valid_in  = 1'b0;
         s1_a_done_in = 1'b0;
      end else if (emit_a) begin
         s1_a_done_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !out_free;
      rsp_pos_x_in = rsp_pos_x_ff;
      rsp_pos_y_in = rsp_pos_y_ff;
      rsp_pos_z_in = rsp_pos_z_ff;
      rsp_class_in = rsp_class_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_a) begin
         rsp_valid_in = 1'b1;
         rsp_pos_x_in = vsc_pkg::POS_W'(s1_x_ff);
         rsp_pos_y_in = vsc_pkg::POS_W'(s1_y_ff);
         rsp_pos_z_in = vsc_pkg::POS_W'(zc);
         rsp_class_in = class_a;
         rsp_last_in  = 1'b0;
      end else if (emit_b) begin
         rsp_valid_in = 1'b1;
         rsp_pos_x_in = vsc_pkg::POS_W'(s1_x_ff);
         rsp_pos_y_in = vsc_pkg::POS_W'(s1_y_ff);
         rsp_pos_z_in = vsc_pkg::POS_W'(s1_z_ff);
         rsp_class_in = class_b;
         rsp_last_in  = s1_flags_ff.last_voxel;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff    <= vsc_pkg::SIZE_X_RESET;
         size_y_ff    <= vsc_pkg::SIZE_Y_RESET;
         size_z_ff    <= vsc_pkg::SIZE_Z_RESET;
         in_x_ff      <= '0;
         in_y_ff      <= '0;
         in_z_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s1_a_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_x_ff    <= size_x_in;
         size_y_ff    <= size_y_in;
         size_z_ff    <= size_z_in;
         in_x_ff      <= in_x_in;
         in_y_ff      <= in_y_in;
         in_z_ff      <= in_z_in;
         s1_valid_ff  <= s1_valid_in;
         s1_a_done_ff <= s1_a_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff     <= in_x_ff;
         s1_y_ff     <= in_y_ff;
         s1_z_ff     <= in_z_ff;
         s1_cur_ff   <= req_occupied;
         s1_flags_ff <= flags_c;
         s1_left_ff  <= nb_center;
      end
      rsp_pos_x_ff <= rsp_pos_x_in;
      rsp_pos_y_ff <= rsp_pos_y_in;
      rsp_pos_z_ff <= rsp_pos_z_in;
      rsp_class_ff <= rsp_class_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = rsp_pos_x_ff;
   assign rsp_pos_y          = rsp_pos_y_ff;
   assign rsp_pos_z          = rsp_pos_z_ff;
   assign rsp_voxel_class    = rsp_class_ff;
   assign rsp_last_of_volume = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_done_needs_pair: assert property (@(posedge clock) disable iff (reset)
      s1_a_done_ff |-> s1_valid_ff && s1_flags_ff.last_plane && s1_flags_ff.has_prev)
      else $error("plane-below result marked done on a word without a second result");

   a_done_then_self: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_a_done_ff && out_free |-> emit_b)
      else $error("last-plane result not sent after the plane-below result");

   silent_word_passes: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_flags_ff.has_prev && !s1_flags_ff.last_plane |-> !req_stall)
      else $error("word without results holds the input side");

   emit_reaches_output: assert property (@(posedge clock) disable iff (reset)
      emit_a || emit_b |=> rsp_valid_ff)
      else $error("result lost on its way to the output register");

endmodule
